/* rtl/cst_pkg.sv */
package cst_pkg;

    // Tokeniser modes; also the token type codes carried on results
    typedef enum logic [2:0] {
        MODE_NONE     = 3'd0,
        MODE_IDENT    = 3'd1,
        MODE_NUMBER   = 3'd2,
        MODE_STRING   = 3'd3,
        MODE_COMMENT  = 3'd4,
        MODE_OPERATOR = 3'd5,
        MODE_BRACKET  = 3'd6
    } mode_t;

    localparam int MAX_RES    = 3;
    localparam int CNT_W      = $clog2(MAX_RES + 1);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] next_ch;
        logic       next_valid;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_out;
        logic [2:0] token_kind;
        logic       run_last;
    } out_word_t;

    // One result without its run marker
    typedef struct packed {
        logic       kind;
        logic [7:0] char_out;
        logic [2:0] token_kind;
    } res_t;

    // All results caused by one character
    typedef struct packed {
        logic [CNT_W-1:0]       cnt;
        res_t [MAX_RES-1:0]     res;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } fifo_wr_t;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [FIFO_CW-1:0] count;
    } fifo_stat_t;

endpackage

/* rtl/cst_front.sv */
module cst_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  cst_pkg::in_word_t item,
    output cst_pkg::fifo_wr_t wr
);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE_RST = 8'h5F;

    function automatic logic is_symbol(input logic [7:0] c);
        is_symbol = (c == 8'h2B) || (c == 8'h2D) || (c == CH_STAR) || (c == CH_SLASH) ||
                    (c == 8'h3D) || (c == 8'h3C) || (c == 8'h3E) || (c == 8'h21) ||
                    (c == CH_DOT) || (c == 8'h2C);
    endfunction

    function automatic cst_pkg::mode_t classify(input logic [7:0] c, input logic [7:0] nx,
                                                input logic nv);
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
            classify = cst_pkg::MODE_IDENT;
        else if (c >= 8'h30 && c <= 8'h39)
            classify = cst_pkg::MODE_NUMBER;
        else if (c == CH_DQ || c == CH_SQ)
            classify = cst_pkg::MODE_STRING;
        else if (c == CH_SLASH && nv && nx == CH_STAR)
            classify = cst_pkg::MODE_COMMENT;
        else if (is_symbol(c))
            classify = cst_pkg::MODE_OPERATOR;
        else if (c == CH_LPAR || c == CH_RPAR)
            classify = cst_pkg::MODE_BRACKET;
        else
            classify = cst_pkg::MODE_NONE;
    endfunction

    cst_pkg::mode_t mode_reg, mode_next;
    logic [7:0]     quote_reg, quote_next;
    logic [7:0]     prev_reg, prev_next;
    logic           has_reg, has_next;

    cst_pkg::mode_t             t;
    logic                       sp;
    logic [cst_pkg::CNT_W-1:0]  n;
    cst_pkg::res_t [3:0]        res;

    always_comb
    begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        has_next   = has_reg;
        prev_next  = item.ch;
        n          = '0;
        res        = '0;
        t          = classify(item.ch, item.next_ch, item.next_valid);
        sp         = (item.ch == CH_SPACE) || (item.ch == CH_NL) || (item.ch == CH_TAB);

        if (mode_reg == cst_pkg::MODE_COMMENT)
        begin
            if (prev_reg == CH_STAR && item.ch == CH_SLASH)
                mode_next = cst_pkg::MODE_NONE;
        end
        else if (sp && mode_reg != cst_pkg::MODE_STRING)
        begin
            if (mode_reg != cst_pkg::MODE_NONE)
            begin
                res[n] = '{1'b1, 8'h00, mode_reg};
                n = n + 1'b1;
                has_next = 1'b0;
                mode_next = cst_pkg::MODE_NONE;
            end
        end
        else if (mode_reg == cst_pkg::MODE_STRING)
        begin
            if (item.ch == quote_reg)
            begin
                res[n] = '{1'b1, 8'h00, cst_pkg::MODE_STRING};
                n = n + 1'b1;
                has_next = 1'b0;
                mode_next = cst_pkg::MODE_NONE;
            end
            else
            begin
                res[n] = '{1'b0, item.ch, cst_pkg::MODE_STRING};
                n = n + 1'b1;
                has_next = 1'b1;
            end
        end
        else
        begin
            // close the open token when the class changes (a dot keeps a number)
            if (mode_reg != cst_pkg::MODE_NONE && t != mode_reg &&
                !(mode_reg == cst_pkg::MODE_NUMBER && item.ch == CH_DOT))
            begin
                res[n] = '{1'b1, 8'h00, mode_reg};
                n = n + 1'b1;
                has_next = 1'b0;
                mode_next = cst_pkg::MODE_NONE;
            end
            if (mode_next == cst_pkg::MODE_NONE)
            begin
                mode_next = t;
                if (t == cst_pkg::MODE_STRING)
                    quote_next = item.ch;
                else if (t == cst_pkg::MODE_BRACKET)
                begin
                    res[n] = '{1'b0, item.ch, cst_pkg::MODE_BRACKET};
                    n = n + 1'b1;
                    res[n] = '{1'b1, 8'h00, cst_pkg::MODE_BRACKET};
                    n = n + 1'b1;
                    has_next = 1'b0;
                    mode_next = cst_pkg::MODE_NONE;
                end
                else if (t != cst_pkg::MODE_COMMENT)
                begin
                    res[n] = '{1'b0, item.ch, t};
                    n = n + 1'b1;
                    has_next = 1'b1;
                end
            end
            else
            begin
                res[n] = '{1'b0, item.ch, mode_reg};
                n = n + 1'b1;
                has_next = 1'b1;
            end
        end

        // flush at end of text, then drop back to reset state
        if (item.end_of_text)
        begin
            if (has_next)
            begin
                res[n] = '{1'b1, 8'h00, mode_next};
                n = n + 1'b1;
            end
            mode_next  = cst_pkg::MODE_NONE;
            quote_next = CH_QUOTE_RST;
            prev_next  = 8'h00;
            has_next   = 1'b0;
        end
    end

    always_comb
    begin
        wr.valid      = take && (n != '0);
        wr.bundle.cnt = n;
        wr.bundle.res = res[cst_pkg::MAX_RES-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= cst_pkg::MODE_NONE;
            quote_reg <= CH_QUOTE_RST;
            prev_reg  <= 8'h00;
            has_reg   <= 1'b0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            prev_reg  <= prev_next;
            has_reg   <= has_next;
        end
    end

endmodule

/* rtl/cst_fifo.sv */
module cst_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  cst_pkg::fifo_wr_t  wr,
    input  logic               rd,
    output cst_pkg::bundle_t   head,
    output cst_pkg::fifo_stat_t stat
);

    cst_pkg::bundle_t [cst_pkg::FIFO_DEPTH-1:0] slot_reg;
    logic [cst_pkg::FIFO_AW-1:0] wp_reg, wp_next;
    logic [cst_pkg::FIFO_AW-1:0] rp_reg, rp_next;
    logic [cst_pkg::FIFO_CW-1:0] cnt_reg, cnt_next;
    logic do_wr, do_rd;

    localparam logic [cst_pkg::FIFO_AW-1:0] LAST_IDX = cst_pkg::FIFO_AW'(cst_pkg::FIFO_DEPTH - 1);
    localparam logic [cst_pkg::FIFO_CW-1:0] DEPTH_C  = cst_pkg::FIFO_CW'(cst_pkg::FIFO_DEPTH);

    always_comb
    begin
        stat.empty = (cnt_reg == '0);
        stat.full  = (cnt_reg == DEPTH_C);
        stat.count = cnt_reg;
        do_wr      = wr.valid && !stat.full;
        do_rd      = rd && !stat.empty;
        wp_next    = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
        rp_next    = (rp_reg == LAST_IDX) ? '0 : rp_reg + 1'b1;
        cnt_next   = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
        head = slot_reg[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wp_reg] <= wr.bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_next;
            if (do_rd)
                rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/cst_back.sv */
module cst_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cst_pkg::bundle_t   head,
    input  logic               empty,
    input  logic               pop,
    output cst_pkg::out_word_t result,
    output logic               rd
);

    logic [cst_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                      last;
    cst_pkg::res_t             cur;

    always_comb
    begin
        cur  = head.res[idx_reg[$clog2(cst_pkg::MAX_RES)-1:0]];
        last = (idx_reg == head.cnt - 1'b1);
        result.kind       = cur.kind;
        result.char_out   = cur.char_out;
        result.token_kind = cur.token_kind;
        result.run_last   = last;
        rd       = pop && !empty && last;
        idx_next = idx_reg;
        if (pop && !empty)
            idx_next = last ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

/* rtl/char_stream_tokenizer_core.sv */
// Character stream tokeniser.
// Input queue side: drive one character word on item (ch, one-character
// lookahead next_ch/next_valid, end_of_text on the final character) and raise
// push; the word is taken on a clock edge where push is high and full is low.
// Result queue side: while empty is low the oldest result word sits on
// result (kind, char_out, token_kind, run_last); pop takes it on an edge
// where pop is high and empty is low. run_last marks the final result word
// caused by one character; characters that cause no result produce nothing.
// A character's results are written into the queue on the edge that takes it.
// Throughput: one character per cycle at the input while full is low. The
// result port drains one word per cycle while pop is high, so a character
// causing k results (at most 3) holds the output for k words; a two-entry
// queue between classifier and output serialiser absorbs this and sets full.
// Reset: mode none, quote 0x5F, previous character zero, queue empty.
// When the receiver stalls, results wait in the queue; once it holds two
// characters' worth full rises and input words are held off.
module char_stream_tokenizer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  cst_pkg::in_word_t  item,
    output logic               empty,
    input  logic               pop,
    output cst_pkg::out_word_t result
);

    cst_pkg::fifo_wr_t   wr;
    cst_pkg::bundle_t    head;
    cst_pkg::fifo_stat_t stat;
    logic                take;
    logic                rd;

    // accept a word only when the queue has room
    assign take  = push && !stat.full;
    assign full  = stat.full;
    assign empty = stat.empty;

    cst_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .wr    (wr)
    );

    cst_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .head  (head),
        .stat  (stat)
    );

    cst_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (stat.empty),
        .pop    (pop),
        .result (result),
        .rd     (rd)
    );

`ifndef SYNTH
    // release a queue entry only on the last word of its character
    a_rd_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> (pop && !stat.empty && result.run_last))
        else $error("queue entry released early");

    // a token end word never carries a character
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!stat.empty && result.kind) |-> (result.char_out == 8'h00))
        else $error("token end carries a character");

    // a write without a read grows the queue by one
    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.valid && !rd) |=> (stat.count == $past(stat.count) + 1'b1))
        else $error("queue count lost a write");

    // the classifier only writes words it has taken
    a_wr_take: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid |-> take)
        else $error("queue written without an accepted word");
`endif

endmodule
